// ===== design/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They compile away when
// NO_ASSERTIONS is defined.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== design/ssfq_pkg.sv =====
// -----------------------------------------------------------------------------
// Service queue package
// Sizes, payload types and small helpers of the single-server service queue.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssfq_pkg;

  // Number of waiting entries the queue can hold.
  localparam int QueueDepth = 64;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);

  localparam int DurW   = 16;
  localparam int TimeW  = 32;
  localparam int CntW   = 32;
  localparam int SumW   = 48;
  localparam int QlenW  = 7;

  typedef enum logic [0:0] {
    OpEnqueue = 1'b0,
    OpTick    = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [DurW-1:0]   service_time;
    logic [TimeW-1:0]  now_time;
  } in_item_t;

  typedef struct packed {
    logic              completed;
    logic              dropped;
    logic [QlenW-1:0]  queue_length;
    logic [CntW-1:0]   served_count;
    logic [CntW-1:0]   started_count;
    logic [SumW-1:0]   wait_total;
    logic [TimeW-1:0]  wait_max;
    logic              sample_valid;
    logic [TimeW-1:0]  wait_sample;
  } out_item_t;

  // One queue entry as stored in the entry memory.
  typedef struct packed {
    logic [DurW-1:0]   duration;
    logic [TimeW-1:0]  arrival;
  } entry_t;

  // Advance a ring pointer, wrapping after the last entry.
  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Increment that holds at the all-ones value.
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== design/single_server_fifo_service_queue.sv =====
// -----------------------------------------------------------------------------
// Single-server service queue
// FIFO of waiting customers in front of one server, with wait statistics.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// The block takes one item, enqueue or tick, in every cycle and returns one
// result for it in the register of the output channel on the next cycle. The
// whole update of an item is done in the cycle of its transfer: the entry at
// the head of the queue is always waiting in a prefetch register, filled from
// the registered read port of the entry memory (with a bypass for an entry
// written to an empty queue), so a tick can start service without a memory
// access of its own. A single output register holds the result; while a result
// waits and the output side is not ready, the input side is stalled, so the
// sustained rate is one item per cycle whenever results are taken as they
// come. The entry memory needs no clearing after reset, since only entries
// that hold queued customers are ever used.
module single_server_fifo_service_queue
  import ssfq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic              busy_q, busy_d;
  logic [DurW-1:0]   remaining_q, remaining_d;
  logic [CntW-1:0]   served_q, served_d;
  logic [CntW-1:0]   started_q, started_d;
  logic [SumW-1:0]   wait_sum_q, wait_sum_d;
  logic [TimeW-1:0]  wait_peak_q, wait_peak_d;

  logic              out_valid_q;
  out_item_t         out_data_q;

  // Entry memory and its head prefetch.
  entry_t            entry_mem [QueueDepth];
  entry_t            head_data_q;
  logic              byp_q;
  entry_t            byp_data_q;
  entry_t            head_entry;

  // Per-item working values.
  logic              in_fire;
  logic              wr_en;
  entry_t            wr_data;
  logic              start;
  logic              busy_n;
  logic [DurW-1:0]   rem;
  logic [TimeW-1:0]  wait_val;
  logic [SumW:0]     sum_ext;
  logic [CountW:0]   occupancy;
  out_item_t         result;

  // A new item is taken whenever the output register is free or drains now.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The head entry comes from the write bypass when the entry was written
  // into the head slot in the previous cycle, and from the read port otherwise.
  assign head_entry = byp_q ? byp_data_q : head_data_q;

  // An enqueued duration of zero is stored as one tick.
  assign wr_data.duration = (in_data_i.service_time == '0) ? DurW'(1)
                                                            : in_data_i.service_time;
  assign wr_data.arrival  = in_data_i.now_time;

  // ---------------------------------------------------------------------------
  // Item processing
  // ---------------------------------------------------------------------------
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    busy_d      = busy_q;
    remaining_d = remaining_q;
    served_d    = served_q;
    started_d   = started_q;
    wait_sum_d  = wait_sum_q;
    wait_peak_d = wait_peak_q;

    wr_en    = 1'b0;
    start    = 1'b0;
    busy_n   = busy_q;
    rem      = remaining_q;
    wait_val = '0;
    sum_ext  = '0;

    result.completed    = 1'b0;
    result.dropped      = 1'b0;
    result.sample_valid = 1'b0;
    result.wait_sample  = '0;

    if (in_fire) begin
      unique case (in_data_i.opcode)
        OpEnqueue: begin
          if (fill_q == CountW'(QueueDepth)) begin
            // Full queue: the customer is discarded and nothing else changes.
            result.dropped = 1'b1;
          end else begin
            wr_en  = 1'b1;
            tail_d = next_ptr(tail_q);
            fill_d = fill_q + 1'b1;
          end
        end
        OpTick: begin
          start = !busy_q && (fill_q != '0);
          if (start) begin
            // A clock that went backwards counts as no wait at all.
            wait_val = (in_data_i.now_time >= head_entry.arrival) ?
                       in_data_i.now_time - head_entry.arrival : '0;
            rem      = head_entry.duration;
            head_d   = next_ptr(head_q);
            fill_d   = fill_q - 1'b1;
            sum_ext  = {1'b0, wait_sum_q} + (SumW + 1)'(wait_val);
            wait_sum_d  = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
            wait_peak_d = (wait_val > wait_peak_q) ? wait_val : wait_peak_q;
            started_d   = sat_inc(started_q);
            busy_n      = 1'b1;
            result.sample_valid = 1'b1;
            result.wait_sample  = wait_val;
          end
          // The server counts down after a possible start, so a one-tick
          // customer starts and completes on the same tick.
          if (busy_n) begin
            if (rem != '0) begin
              rem = rem - 1'b1;
            end
            if (rem == '0) begin
              busy_n           = 1'b0;
              result.completed = 1'b1;
              served_d         = sat_inc(served_q);
            end
          end
          remaining_d = rem;
          busy_d      = busy_n;
        end
        default: begin
        end
      endcase
    end

    occupancy = {1'b0, fill_d} + (CountW + 1)'(busy_d);

    result.queue_length  = QlenW'(occupancy);
    result.served_count  = served_d;
    result.started_count = started_d;
    result.wait_total    = wait_sum_d;
    result.wait_max      = wait_peak_d;
  end

  // ---------------------------------------------------------------------------
  // Control and statistics registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      busy_q      <= 1'b0;
      remaining_q <= '0;
      served_q    <= '0;
      started_q   <= '0;
      wait_sum_q  <= '0;
      wait_peak_q <= '0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      busy_q      <= busy_d;
      remaining_q <= remaining_d;
      served_q    <= served_d;
      started_q   <= started_d;
      wait_sum_q  <= wait_sum_d;
      wait_peak_q <= wait_peak_d;
      byp_q       <= wr_en && (tail_q == head_d);
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each transfer on the input side.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= result;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry memory: one write port at the tail, one registered read port that
  // always fetches the entry at the next head position.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[tail_q] <= wr_data;
    end
    head_data_q <= entry_mem[head_d];
    byp_data_q  <= wr_data;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_PROP(a_fill_in_range, clk_i, rst_ni, fill_q <= CountW'(QueueDepth))
  `ASSERT_PROP(a_ptrs_meet_when_empty, clk_i, rst_ni,
               (fill_q == '0 || fill_q == CountW'(QueueDepth)) |-> (tail_q == head_q))
  `ASSERT_NEVER(a_busy_with_no_time, clk_i, rst_ni, busy_q && (remaining_q == '0))
  `ASSERT_PROP(a_served_not_above_started, clk_i, rst_ni, served_q <= started_q)
  `ASSERT_PROP(a_result_follows_transfer, clk_i, rst_ni, in_fire |=> out_valid_q)

endmodule

`default_nettype wire
